// ===== sv/lpi_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and codes for the LED position interpolator.
// Used by lpi_node_table, lpi_serial_div, the top level and the checker.
package lpi_pkg;

   localparam int unsigned COORD_W   = 16;
   localparam int unsigned PROD_W    = 2 * COORD_W;
   localparam int unsigned DIV_STEPS = COORD_W;
   localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   localparam logic [2:0] REGION_EMPTY  = 3'd0;
   localparam logic [2:0] REGION_FIRST  = 3'd1;
   localparam logic [2:0] REGION_LAST   = 3'd2;
   localparam logic [2:0] REGION_INTERP = 3'd3;
   localparam logic [2:0] REGION_NONE   = 3'd4;

   typedef struct packed {
      logic [COORD_W-1:0] led;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] z;
   } node_type;

   typedef struct packed {
      logic              start;
      logic [PROD_W-1:0] dividend;
      logic [COORD_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [COORD_W-1:0] quotient;
   } div_rsp_type;

endpackage

// ===== sv/lpi_node_table.sv =====
`timescale 1ns / 1ps
// Breakpoint memory: one write port, one read port with registered data.
// Depends on lpi_pkg (node_type).
module lpi_node_table #(
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  lpi_pkg::node_type        wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output lpi_pkg::node_type        rd_data
);

   lpi_pkg::node_type mem [DEPTH];
   lpi_pkg::node_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/lpi_serial_div.sv =====
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, 16-bit quotient.
// Requires dividend / divisor < 2**16. Depends on lpi_pkg.
module lpi_serial_div (
   input  logic                 clock,
   input  logic                 reset,
   input  lpi_pkg::div_req_type req,
   output lpi_pkg::div_rsp_type rsp
);

   logic [lpi_pkg::COORD_W-1:0]   rem_ff, rem_in;
   logic [lpi_pkg::COORD_W-1:0]   quo_ff, quo_in;
   logic [lpi_pkg::COORD_W-1:0]   div_ff, div_in;
   logic [lpi_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                          run_ff, run_in;
   logic                          done_ff, done_in;
   logic [lpi_pkg::COORD_W:0]     shifted;
   logic [lpi_pkg::COORD_W:0]     trial;

   always_comb begin
      shifted = {rem_ff, quo_ff[lpi_pkg::COORD_W-1]};
      trial   = shifted - {1'b0, div_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (req.start) begin
         rem_in = req.dividend[lpi_pkg::PROD_W-1:lpi_pkg::COORD_W];
         quo_in = req.dividend[lpi_pkg::COORD_W-1:0];
         div_in = req.divisor;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         if (!trial[lpi_pkg::COORD_W]) begin
            rem_in = trial[lpi_pkg::COORD_W-1:0];
            quo_in = {quo_ff[lpi_pkg::COORD_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[lpi_pkg::COORD_W-1:0];
            quo_in = {quo_ff[lpi_pkg::COORD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == lpi_pkg::DIV_CNT_W'(lpi_pkg::DIV_STEPS - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
      if (reset) begin
         cnt_ff  <= '0;
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

// ===== sv/led_position_interpolator_unit.sv =====
`timescale 1ns / 1ps
// Top level: breakpoint table, segment scan sequencer and shared mul/divide.
// Depends on lpi_pkg, lpi_node_table, lpi_serial_div.
//
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+------------------------
//  request  | req_command/slot/node_*/led_index       | start & !busy
//  response | rsp_pos_x/y/z, rsp_region               | rsp_strobe, one cycle
//  config   | csr_node_count                          | csr_valid & csr_ready
//
// A load request never raises busy; an empty-table query answers the next
// cycle. Clamped queries are answered from the end checks (first node, then
// last node); a scan steps through the segments in order, and an interpolation
// runs per coordinate a multiply, a divider launch and a 16-step divide.
// Reset clears the sequencer and node_count; table contents are undefined.
// The receiver cannot stall; each response is a single-cycle strobe.
module led_position_interpolator_unit #(
   parameter int unsigned MAX_NODES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_command,
   input  logic [3:0]  req_slot,
   input  logic [15:0] req_node_led,
   input  logic signed [15:0] req_node_x,
   input  logic signed [15:0] req_node_y,
   input  logic signed [15:0] req_node_z,
   input  logic [15:0] req_led_index,
   output logic        rsp_strobe,
   output logic signed [15:0] rsp_pos_x,
   output logic signed [15:0] rsp_pos_y,
   output logic signed [15:0] rsp_pos_z,
   output logic [2:0]  rsp_region,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [4:0]  csr_node_count
);

   localparam int unsigned AW = $clog2(MAX_NODES);
   localparam int unsigned NW = AW + 1;

   typedef enum logic [2:0] {
      ST_IDLE, ST_CHECK_FIRST, ST_CHECK_LAST, ST_SCAN, ST_MULTIPLY, ST_DIV_GO, ST_DIVIDE
   } state_type;

   state_type         state_ff, state_in;
   logic [4:0]        count_ff, count_in;
   logic [AW-1:0]     addr_ff, addr_in;
   logic [AW-1:0]     last_ff, last_in;
   logic [15:0]       led_ff, led_in;
   lpi_pkg::node_type a_ff, a_in;
   lpi_pkg::node_type b_ff, b_in;
   logic [15:0]       dist_ff, dist_in;
   logic [15:0]       span_ff, span_in;
   logic [1:0]        coord_ff, coord_in;
   logic              neg_ff, neg_in;
   logic [31:0]       prod_ff, prod_in;
   logic              strobe_ff, strobe_in;
   logic [15:0]       pos_x_ff, pos_x_in;
   logic [15:0]       pos_y_ff, pos_y_in;
   logic [15:0]       pos_z_ff, pos_z_in;
   logic [2:0]        region_ff, region_in;

   logic              wr_en;
   lpi_pkg::node_type wr_data;
   lpi_pkg::node_type rd_data;
   lpi_pkg::div_req_type div_req;
   lpi_pkg::div_rsp_type div_rsp;

   logic [NW-1:0]     n_now;
   logic [15:0]       ca, cb;
   logic [16:0]       diff;
   logic [15:0]       mag;
   logic [16:0]       coord_sum;

   assign wr_data = '{led: req_node_led, x: req_node_x, y: req_node_y, z: req_node_z};

   lpi_node_table #(.DEPTH(MAX_NODES)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (AW'(req_slot)),
      .wr_data (wr_data),
      .rd_addr (addr_in),
      .rd_data (rd_data)
   );

   lpi_serial_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   always_comb begin
      n_now = (32'(count_ff) > 32'(MAX_NODES)) ? NW'(MAX_NODES) : NW'(count_ff);
      case (coord_ff)
         2'd0:    begin ca = a_ff.x; cb = b_ff.x; end
         2'd1:    begin ca = a_ff.y; cb = b_ff.y; end
         default: begin ca = a_ff.z; cb = b_ff.z; end
      endcase
      diff = {cb[15], cb} - {ca[15], ca};
      mag  = diff[16] ? 16'(-diff) : diff[15:0];
      coord_sum = {ca[15], ca} +
                  (neg_ff ? -{1'b0, div_rsp.quotient} : {1'b0, div_rsp.quotient});
   end

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      addr_in   = addr_ff;
      last_in   = last_ff;
      led_in    = led_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      dist_in   = dist_ff;
      span_in   = span_ff;
      coord_in  = coord_ff;
      neg_in    = neg_ff;
      prod_in   = prod_ff;
      strobe_in = 1'b0;
      pos_x_in  = pos_x_ff;
      pos_y_in  = pos_y_ff;
      pos_z_in  = pos_z_ff;
      region_in = region_ff;
      wr_en     = 1'b0;
      div_req   = '{start: 1'b0, dividend: prod_ff, divisor: span_ff};

      if (csr_valid && csr_ready) begin
         count_in = csr_node_count;
      end

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_command == lpi_pkg::CMD_QUERY) begin
                  led_in = req_led_index;
                  if (n_now == '0) begin
                     strobe_in = 1'b1;
                     pos_x_in  = '0;
                     pos_y_in  = '0;
                     pos_z_in  = '0;
                     region_in = lpi_pkg::REGION_EMPTY;
                  end else begin
                     last_in  = AW'(n_now - 1'b1);
                     addr_in  = '0;
                     state_in = ST_CHECK_FIRST;
                  end
               end else if (32'(req_slot) < 32'(MAX_NODES)) begin
                  wr_en = 1'b1;
               end
            end
         end
         ST_CHECK_FIRST: begin
            a_in = rd_data;
            if (led_ff <= rd_data.led) begin
               strobe_in = 1'b1;
               pos_x_in  = rd_data.x;
               pos_y_in  = rd_data.y;
               pos_z_in  = rd_data.z;
               region_in = lpi_pkg::REGION_FIRST;
               state_in  = ST_IDLE;
            end else begin
               addr_in  = last_ff;
               state_in = ST_CHECK_LAST;
            end
         end
         ST_CHECK_LAST: begin
            if (led_ff >= rd_data.led) begin
               strobe_in = 1'b1;
               pos_x_in  = rd_data.x;
               pos_y_in  = rd_data.y;
               pos_z_in  = rd_data.z;
               region_in = lpi_pkg::REGION_LAST;
               state_in  = ST_IDLE;
            end else begin
               addr_in  = AW'(1);
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (led_ff >= a_ff.led && led_ff <= rd_data.led) begin
               b_in    = rd_data;
               dist_in = led_ff - a_ff.led;
               span_in = rd_data.led - a_ff.led;
               if (rd_data.led == a_ff.led) begin
                  strobe_in = 1'b1;
                  pos_x_in  = a_ff.x;
                  pos_y_in  = a_ff.y;
                  pos_z_in  = a_ff.z;
                  region_in = lpi_pkg::REGION_INTERP;
                  state_in  = ST_IDLE;
               end else begin
                  coord_in = 2'd0;
                  state_in = ST_MULTIPLY;
               end
            end else if (addr_ff == last_ff) begin
               strobe_in = 1'b1;
               pos_x_in  = '0;
               pos_y_in  = '0;
               pos_z_in  = '0;
               region_in = lpi_pkg::REGION_NONE;
               state_in  = ST_IDLE;
            end else begin
               a_in    = rd_data;
               addr_in = addr_ff + 1'b1;
            end
         end
         ST_MULTIPLY: begin
            prod_in  = mag * dist_ff;
            neg_in   = diff[16];
            state_in = ST_DIV_GO;
         end
         ST_DIV_GO: begin
            div_req.start = 1'b1;
            state_in      = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (div_rsp.done) begin
               case (coord_ff)
                  2'd0:    pos_x_in = coord_sum[15:0];
                  2'd1:    pos_y_in = coord_sum[15:0];
                  default: pos_z_in = coord_sum[15:0];
               endcase
               if (coord_ff == 2'd2) begin
                  strobe_in = 1'b1;
                  region_in = lpi_pkg::REGION_INTERP;
                  state_in  = ST_IDLE;
               end else begin
                  coord_in = coord_ff + 1'b1;
                  state_in = ST_MULTIPLY;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      addr_ff   <= addr_in;
      last_ff   <= last_in;
      led_ff    <= led_in;
      a_ff      <= a_in;
      b_ff      <= b_in;
      dist_ff   <= dist_in;
      span_ff   <= span_in;
      coord_ff  <= coord_in;
      neg_ff    <= neg_in;
      prod_ff   <= prod_in;
      pos_x_ff  <= pos_x_in;
      pos_y_ff  <= pos_y_in;
      pos_z_ff  <= pos_z_in;
      region_ff <= region_in;
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
   end

   assign busy       = (state_ff != ST_IDLE);
   assign csr_ready  = (state_ff == ST_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_pos_x  = pos_x_ff;
   assign rsp_pos_y  = pos_y_ff;
   assign rsp_pos_z  = pos_z_ff;
   assign rsp_region = region_ff;

endmodule

// ===== sv/lpi_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for led_position_interpolator_unit, attached by bind.
// Depends on lpi_pkg for command and region codes.
module lpi_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        req_command,
   input logic        rsp_strobe,
   input logic [15:0] rsp_pos_x,
   input logic [15:0] rsp_pos_y,
   input logic [15:0] rsp_pos_z,
   input logic [2:0]  rsp_region
);

   a_query_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_command == lpi_pkg::CMD_QUERY) |=> (busy || rsp_strobe))
      else $error("query accepted but neither busy nor answered");

   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_command == lpi_pkg::CMD_LOAD) |=> (!busy && !rsp_strobe))
      else $error("load request produced activity");

   a_done_answers: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_strobe)
      else $error("busy dropped without a response");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("response while busy");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_region == lpi_pkg::REGION_EMPTY) |->
         (rsp_pos_x == '0 && rsp_pos_y == '0 && rsp_pos_z == '0))
      else $error("empty-table response with nonzero position");

endmodule

bind led_position_interpolator_unit lpi_checker u_lpi_checker (.*);
